[sv/klp_pkg.sv]
package klp_pkg;

    localparam int CODE_W   = 10;
    localparam int TICKS_W  = 8;
    localparam int CYCLE_W  = TICKS_W + 1;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [TICKS_W-1:0] LONG_TICKS_RST = 8'd10;
    localparam logic [TICKS_W-1:0] GAP_TICKS_RST  = 8'd10;

    typedef enum logic [2:0] {
        REG_SHORT_CODE  = 3'd0,
        REG_LONG_CODE   = 3'd1,
        REG_LONG_TICKS  = 3'd2,
        REG_GAP_TICKS   = 3'd3,
        REG_WAKE_ENABLE = 3'd4,
        REG_ACTIVE_LOW  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              value;
        logic              last;
    } result_t;

endpackage

[sv/key_long_press_event_generator.sv]
// Flow: a request is registered at acceptance and its events are then written into the
// two-entry event buffer, whose slot 0 drives the outputs, once the buffer has room.
// Rate: one request per cycle while each gives at most one event and out_stall is low;
// the buffer drains one event per cycle unless stalled; a two-event request needs it empty.
// Reset (rst_n, asynchronous, active low) clears the hold count, the timer and the buffers
// and loads the register defaults.
module key_long_press_event_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [klp_pkg::ADDR_W-1:0]    paddr,
    input  logic [klp_pkg::DATA_W-1:0]    pwdata,
    output logic [klp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic                          raw_level,
    input  logic                          suspended,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [klp_pkg::CODE_W-1:0]    key_code,
    output logic                          key_value,
    output logic                          last
);

    localparam int CW = klp_pkg::CODE_W;
    localparam int TW = klp_pkg::TICKS_W;
    localparam int YW = klp_pkg::CYCLE_W;

    // Configuration registers.
    logic [CW-1:0] short_code_reg;
    logic [CW-1:0] long_code_reg;
    logic [TW-1:0] long_ticks_reg;
    logic [TW-1:0] gap_ticks_reg;
    logic          wake_enable_reg;
    logic          active_low_reg;

    logic cfg_write;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_code_reg  <= '0;
            long_code_reg   <= '0;
            long_ticks_reg  <= klp_pkg::LONG_TICKS_RST;
            gap_ticks_reg   <= klp_pkg::GAP_TICKS_RST;
            wake_enable_reg <= 1'b0;
            active_low_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                klp_pkg::REG_SHORT_CODE:  short_code_reg  <= pwdata[CW-1:0];
                klp_pkg::REG_LONG_CODE:   long_code_reg   <= pwdata[CW-1:0];
                klp_pkg::REG_LONG_TICKS:  long_ticks_reg  <= pwdata[TW-1:0];
                klp_pkg::REG_GAP_TICKS:   gap_ticks_reg   <= pwdata[TW-1:0];
                klp_pkg::REG_WAKE_ENABLE: wake_enable_reg <= pwdata[0];
                klp_pkg::REG_ACTIVE_LOW:  active_low_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (paddr[4:2])
            klp_pkg::REG_SHORT_CODE:  prdata[CW-1:0] = short_code_reg;
            klp_pkg::REG_LONG_CODE:   prdata[CW-1:0] = long_code_reg;
            klp_pkg::REG_LONG_TICKS:  prdata[TW-1:0] = long_ticks_reg;
            klp_pkg::REG_GAP_TICKS:   prdata[TW-1:0] = gap_ticks_reg;
            klp_pkg::REG_WAKE_ENABLE: prdata[0]      = wake_enable_reg;
            klp_pkg::REG_ACTIVE_LOW:  prdata[0]      = active_low_reg;
            default:                  prdata         = '0;
        endcase
    end

    // Input register.
    logic in_valid_reg;
    logic action_reg;
    logic raw_level_reg;
    logic suspended_reg;
    logic fire;
    logic in_accept;

    assign in_stall  = in_valid_reg && !fire;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_accept)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg    <= action;
            raw_level_reg <= raw_level;
            suspended_reg <= suspended;
        end
    end

    // Hold count state.
    logic [TW-1:0] long_phase_reg,  long_phase_next;
    logic [YW-1:0] cycle_phase_reg, cycle_phase_next;
    logic past_long_reg,     past_long_next;
    logic count_started_reg, count_started_next;
    logic timer_armed_reg,   timer_armed_next;
    logic last_pressed_reg,  last_pressed_next;

    logic [TW-1:0]   long_period;
    logic [YW-1:0]   cycle_period;
    logic [YW-1:0]   long_inc;
    logic [YW:0]     cycle_inc;
    logic            pressed;
    logic [1:0]      n_results;
    klp_pkg::result_t res0, res1;

    assign long_period  = (long_ticks_reg == '0) ? TW'(1) : long_ticks_reg;
    assign cycle_period = {1'b0, long_period} + {1'b0, gap_ticks_reg};
    assign long_inc     = {1'b0, long_phase_reg} + YW'(1);
    assign cycle_inc    = {1'b0, cycle_phase_reg} + (YW+1)'(1);
    assign pressed      = raw_level_reg ^ active_low_reg;

    always_comb
    begin
        long_phase_next    = long_phase_reg;
        cycle_phase_next   = cycle_phase_reg;
        past_long_next     = past_long_reg;
        count_started_next = count_started_reg;
        timer_armed_next   = timer_armed_reg;
        last_pressed_next  = last_pressed_reg;
        n_results          = 2'd0;
        res0               = '{code: short_code_reg, value: 1'b1, last: 1'b0};
        res1               = '{code: short_code_reg, value: 1'b0, last: 1'b1};

        if (action_reg)
        begin
            if (wake_enable_reg && suspended_reg)
                n_results = 2'd2;
            else
            begin
                long_phase_next    = '0;
                cycle_phase_next   = '0;
                past_long_next     = 1'b0;
                count_started_next = 1'b0;
                timer_armed_next   = 1'b1;
            end
        end
        else if (timer_armed_reg)
        begin
            last_pressed_next = pressed;
            if (pressed)
            begin
                if (count_started_reg)
                begin
                    // The long-plus-gap test wins when both phases are at zero.
                    if (cycle_phase_reg == '0)
                    begin
                        n_results = 2'd1;
                        res0      = '{code: long_code_reg, value: 1'b0, last: 1'b1};
                    end
                    else if (long_phase_reg == '0)
                    begin
                        n_results = 2'd1;
                        res0      = '{code: long_code_reg, value: 1'b1, last: 1'b1};
                    end
                    if (long_phase_reg == '0)
                        past_long_next = 1'b1;
                end
                long_phase_next    = (long_inc >= {1'b0, long_period}) ?
                                     '0 : long_inc[TW-1:0];
                cycle_phase_next   = (cycle_inc >= {1'b0, cycle_period}) ?
                                     '0 : cycle_inc[YW-1:0];
                count_started_next = 1'b1;
            end
            else
            begin
                if (!past_long_reg)
                begin
                    long_phase_next    = '0;
                    cycle_phase_next   = '0;
                    past_long_next     = 1'b0;
                    count_started_next = 1'b0;
                    n_results          = 2'd2;
                end
                else if (last_pressed_reg)
                begin
                    n_results = 2'd1;
                    res0      = '{code: long_code_reg, value: 1'b0, last: 1'b1};
                end
                timer_armed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_phase_reg    <= '0;
            cycle_phase_reg   <= '0;
            past_long_reg     <= 1'b0;
            count_started_reg <= 1'b0;
            timer_armed_reg   <= 1'b0;
            last_pressed_reg  <= 1'b0;
        end
        else if (fire)
        begin
            long_phase_reg    <= long_phase_next;
            cycle_phase_reg   <= cycle_phase_next;
            past_long_reg     <= past_long_next;
            count_started_reg <= count_started_next;
            timer_armed_reg   <= timer_armed_next;
            last_pressed_reg  <= last_pressed_next;
        end
    end

    // Two-entry event buffer; slot 0 drives the outputs.
    klp_pkg::result_t slot0_reg, slot0_next;
    klp_pkg::result_t slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] count_kept;
    logic [1:0] free_slots;
    logic       pop;

    assign out_valid  = (count_reg != 2'd0);
    assign pop        = out_valid && !out_stall;
    assign count_kept = count_reg - {1'b0, pop};
    assign free_slots = 2'd2 - count_kept;
    assign fire       = in_valid_reg && (n_results <= free_slots);
    assign count_next = count_kept + (fire ? n_results : 2'd0);

    always_comb
    begin
        slot0_next = pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        if (fire)
        begin
            case (count_kept)
                2'd0:
                begin
                    if (n_results != 2'd0)
                        slot0_next = res0;
                    if (n_results == 2'd2)
                        slot1_next = res1;
                end
                2'd1:
                begin
                    if (n_results != 2'd0)
                        slot1_next = res0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign key_code  = slot0_reg.code;
    assign key_value = slot0_reg.value;
    assign last      = slot0_reg.last;

endmodule
